// File: hdl/mscc_pkg.sv
// Shared types, codes and default sizes for the match symmetry cross-check.
`timescale 1ns / 1ps

package mscc_pkg;

	localparam int IDX_W = 10;          // width of feature and match number fields
	localparam int EXT_W = 17;          // wide enough to hold table sizes below 2**17
	localparam int DEF_MAX_SOURCE  = 1024;
	localparam int DEF_MAX_MATCHES = 1024;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_FORWARD  = 2'd1,
		OP_BACKWARD = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// File: hdl/match_symmetry_cross_check.sv
// Top level: forward/backward match cross-check built around two table RAMs.
//
// Usage:
//   An item (operation, source_feature, target_feature, match_number) is taken
//   on a rising edge with start high and busy low. Exactly one result beat
//   follows: done is high for one cycle with status, match_index and
//   confirmed valid; there is no back-pressure on the result side.
//   Forward, backward and query items: the table read is launched at the
//   accept edge, the next edge does the write-back and registers the result,
//   which is shown in the cycle after. busy is high while the write-back is
//   pending, so a new item is taken only once the last one's result is
//   registered: the single port of the check table (read, then write) sets this.
//   Clear items walk the check table one entry per cycle: busy stays high through
//   the whole walk, and done is shown in the cycle in which busy falls.
//   Reset: arst_n low clears control state; after release the block runs the
//   same walk over the check table (busy high) before it takes its first
//   item. The match flag table needs no initialization.
//   Results can never be stalled, so no result is ever held or dropped.
`timescale 1ns / 1ps

module match_symmetry_cross_check #(
	parameter int MAX_SOURCE  = mscc_pkg::DEF_MAX_SOURCE,
	parameter int MAX_MATCHES = mscc_pkg::DEF_MAX_MATCHES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [mscc_pkg::IDX_W-1:0] source_feature,
	input  logic [mscc_pkg::IDX_W-1:0] target_feature,
	input  logic [mscc_pkg::IDX_W-1:0] match_number,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [mscc_pkg::IDX_W-1:0] match_index,
	output logic                       confirmed
);

	localparam int IW = mscc_pkg::IDX_W;
	localparam int XW = mscc_pkg::EXT_W;
	localparam int AW = $clog2(MAX_SOURCE);
	localparam int MW = $clog2(MAX_MATCHES);
	localparam int CW = $clog2(MAX_MATCHES + 1);
	localparam int EW = 1 + MW + IW;   // {valid, match number, target}

	localparam logic [XW-1:0] SRC_LIM   = XW'(MAX_SOURCE);
	localparam logic [XW-1:0] MATCH_LIM = XW'(MAX_MATCHES);
	localparam logic [AW-1:0] LAST_SRC  = AW'(MAX_SOURCE - 1);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EVAL,
		S_CLR
	} state_t;

	state_t state_q;
	logic [1:0]    op_q;
	logic [IW-1:0] src_q;
	logic [IW-1:0] dst_q;
	logic [IW-1:0] qk_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [IW-1:0] index_q;
	logic          conf_q;

	logic          accept;
	logic          ent_we;
	logic [AW-1:0] ent_addr;
	logic [EW-1:0] ent_wdata;
	logic [EW-1:0] ent_rdata;
	logic          flg_we;
	logic [MW-1:0] flg_addr;
	logic          flg_wdata;
	logic          flg_rdata;

	logic          ent_valid;
	logic [MW-1:0] ent_match;
	logic [IW-1:0] ent_target;
	logic          src_oor;
	logic          tbl_full;
	logic          bwd_hit;
	logic          qry_oor;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign ent_valid  = ent_rdata[EW-1];
	assign ent_match  = ent_rdata[IW +: MW];
	assign ent_target = ent_rdata[IW-1:0];

	assign src_oor  = XW'(src_q) >= SRC_LIM;
	assign tbl_full = XW'(count_q) >= MATCH_LIM;
	assign bwd_hit  = ent_valid && (ent_target == dst_q);
	assign qry_oor  = (XW'(qk_q) >= XW'(count_q)) || (XW'(qk_q) >= MATCH_LIM);

	// Memory port control: reads launch at accept, write-back in S_EVAL,
	// invalidation sweep in S_INIT / S_CLR.
	always_comb begin
		ent_we    = 1'b0;
		ent_addr  = AW'(source_feature);
		ent_wdata = {1'b1, MW'(count_q), dst_q};
		flg_we    = 1'b0;
		flg_addr  = MW'(match_number);
		flg_wdata = 1'b0;
		case (state_q)
			S_INIT, S_CLR: begin
				ent_we    = 1'b1;
				ent_addr  = ptr_q;
				ent_wdata = '0;
			end
			S_EVAL: begin
				ent_addr = AW'(src_q);
				if (op_q == mscc_pkg::OP_FORWARD) begin
					flg_addr = MW'(count_q);
					if (!src_oor && !tbl_full) begin
						ent_we = 1'b1;
						flg_we = 1'b1;
					end
				end else if (op_q == mscc_pkg::OP_BACKWARD) begin
					flg_addr  = ent_match;
					flg_wdata = 1'b1;
					flg_we    = !src_oor && bwd_hit;
				end else begin
					flg_addr = MW'(qk_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			count_q <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_SRC) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q  <= operation;
						src_q <= source_feature;
						dst_q <= target_feature;
						qk_q  <= match_number;
						state_q <= (operation == mscc_pkg::OP_CLEAR) ? S_CLR : S_EVAL;
					end
				end
				S_CLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_SRC) begin
						ptr_q    <= '0;
						count_q  <= '0;
						done_q   <= 1'b1;
						status_q <= mscc_pkg::ST_OK;
						index_q  <= '0;
						conf_q   <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_EVAL: begin
					done_q   <= 1'b1;
					status_q <= mscc_pkg::ST_OK;
					index_q  <= '0;
					conf_q   <= 1'b0;
					state_q  <= S_IDLE;
					if (op_q == mscc_pkg::OP_FORWARD) begin
						if (src_oor) begin
							status_q <= mscc_pkg::ST_RANGE;
						end else if (tbl_full) begin
							status_q <= mscc_pkg::ST_FULL;
						end else begin
							index_q <= IW'(count_q);
							count_q <= count_q + 1'b1;
						end
					end else if (op_q == mscc_pkg::OP_BACKWARD) begin
						if (src_oor) begin
							status_q <= mscc_pkg::ST_RANGE;
						end else if (bwd_hit) begin
							index_q <= IW'(ent_match);
							conf_q  <= 1'b1;
						end
					end else begin
						if (qry_oor) begin
							status_q <= mscc_pkg::ST_RANGE;
						end else begin
							index_q <= qk_q;
							conf_q  <= flg_rdata;
						end
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign match_index = index_q;
	assign confirmed   = conf_q;

	mscc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SOURCE)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.addr (ent_addr),
		.wdata(ent_wdata),
		.rdata(ent_rdata)
	);

	mscc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_MATCHES)
	) u_flag_ram (
		.clk  (clk),
		.we   (flg_we),
		.addr (flg_addr),
		.wdata(flg_wdata),
		.rdata(flg_rdata)
	);

	// A result beat only ever leaves with the controller back in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted item always occupies the controller for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item accepted without going busy");

	// Match numbering never runs past the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= MATCH_LIM)
		else $error("match count beyond table");

	// A confirmed verdict always comes with an ok status.
	a_conf_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && confirmed) |-> (status == mscc_pkg::ST_OK))
		else $error("confirmed with error status");

	// Full status only when every match number is taken.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == mscc_pkg::ST_FULL) |-> (XW'(count_q) == MATCH_LIM))
		else $error("full status with free match numbers");

	// No table write while idle; reads there must not disturb entries.
	a_idle_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!ent_we && !flg_we))
		else $error("table write in idle");

endmodule

// File: hdl/mscc_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mscc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: bench/tb_match_symmetry_cross_check.sv
// Self-checking testbench for the forward/backward match symmetry cross-check.
`timescale 1ns / 1ps

module tb_match_symmetry_cross_check;

	localparam int IW           = mscc_pkg::IDX_W;
	localparam int N_SRC        = mscc_pkg::DEF_MAX_SOURCE;
	localparam int N_MATCH      = mscc_pkg::DEF_MAX_MATCHES;
	localparam int RANDOM_ITEMS = 760;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		mscc_pkg::status_t status;
		logic [IW-1:0]     index;
		logic              confirmed;
	} verdict_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    operation;
	logic [IW-1:0] source_feature;
	logic [IW-1:0] target_feature;
	logic [IW-1:0] match_number;
	logic          done;
	logic [1:0]    status;
	logic [IW-1:0] match_index;
	logic          confirmed;

	// shadow copy of the check table and the match flags
	bit            src_valid  [N_SRC];
	logic [IW-1:0] src_match  [N_SRC];
	logic [IW-1:0] src_target [N_SRC];
	bit            match_sym  [N_MATCH];
	int            match_count;

	verdict_t      verdict_q [$];
	logic [IW-1:0] recent_src [$];
	logic [IW-1:0] recent_tgt [$];

	int n_sent;
	int n_checked;
	int n_clears;
	int n_confirms;
	int errors;
	int cycles;
	bit gaps_on;

	match_symmetry_cross_check u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.source_feature (source_feature),
		.target_feature (target_feature),
		.match_number   (match_number),
		.done           (done),
		.status         (status),
		.match_index    (match_index),
		.confirmed      (confirmed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [IW-1:0] any_idx();
		return IW'($urandom_range(N_SRC - 1));
	endfunction

	function automatic verdict_t predict_verdict(input mscc_pkg::op_t op,
			input logic [IW-1:0] src, input logic [IW-1:0] tgt, input logic [IW-1:0] num);
		verdict_t v;
		v = '{mscc_pkg::ST_OK, '0, 1'b0};
		case (op)
			mscc_pkg::OP_CLEAR: begin
				for (int i = 0; i < N_SRC; i++)
					src_valid[i] = 1'b0;
				match_count = 0;
				n_clears++;
			end
			mscc_pkg::OP_FORWARD: begin
				if (int'(src) >= N_SRC) begin
					v.status = mscc_pkg::ST_RANGE;
				end else if (match_count >= N_MATCH) begin
					v.status = mscc_pkg::ST_FULL;
				end else begin
					src_valid[src]  = 1'b1;
					src_match[src]  = IW'(match_count);
					src_target[src] = tgt;
					match_sym[match_count] = 1'b0;
					v.index = IW'(match_count);
					match_count++;
				end
			end
			mscc_pkg::OP_BACKWARD: begin
				if (int'(src) >= N_SRC) begin
					v.status = mscc_pkg::ST_RANGE;
				end else if (src_valid[src] && src_target[src] == tgt) begin
					match_sym[src_match[src]] = 1'b1;
					v.index = src_match[src];
					v.confirmed = 1'b1;
					n_confirms++;
				end
			end
			default: begin
				if (int'(num) >= match_count) begin
					v.status = mscc_pkg::ST_RANGE;
				end else begin
					v.index = num;
					v.confirmed = match_sym[num];
				end
			end
		endcase
		return v;
	endfunction

	// one item beat; start may stay high straight into the next call
	task automatic send_item(input mscc_pkg::op_t op, input logic [IW-1:0] src,
			input logic [IW-1:0] tgt, input logic [IW-1:0] num);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 8) begin
			start = 1'b0;
			operation = 2'($urandom_range(3));
			source_feature = any_idx();
			target_feature = any_idx();
			match_number = any_idx();
			@(negedge clk);
		end
		start = 1'b1;
		operation = op;
		source_feature = src;
		target_feature = tgt;
		match_number = num;
		// taken at the first rising edge that sees busy low
		do
			@(posedge clk);
		while (busy !== 1'b0);
		verdict_q = {verdict_q, predict_verdict(op, src, tgt, num)};
		n_sent++;
	endtask

	// forwards with random content, most followed by a backward check or a query
	task automatic run_burst(input int n_fwd, input int span);
		int base;
		int pick;
		int r;
		int q_lim;
		logic [IW-1:0] s;
		logic [IW-1:0] t;
		base = $urandom_range(N_SRC - span);
		recent_src.delete();
		recent_tgt.delete();
		for (int i = 0; i < n_fwd; i++) begin
			s = IW'(base + $urandom_range(span - 1));
			t = any_idx();
			send_item(mscc_pkg::OP_FORWARD, s, t, any_idx());
			recent_src = {recent_src, s};
			recent_tgt = {recent_tgt, t};
			if (recent_src.size() > 16) begin
				void'(recent_src.pop_front());
				void'(recent_tgt.pop_front());
			end
			pick = $urandom_range(recent_src.size() - 1);
			q_lim = (match_count + 1 > N_MATCH - 1) ? N_MATCH - 1 : match_count + 1;
			r = $urandom_range(99);
			if (r < 45)
				send_item(mscc_pkg::OP_BACKWARD, recent_src[pick], recent_tgt[pick],
					any_idx());
			else if (r < 55)
				send_item(mscc_pkg::OP_BACKWARD, recent_src[pick],
					recent_tgt[pick] ^ IW'($urandom_range(1, N_SRC - 1)), any_idx());
			else if (r < 70)
				send_item(mscc_pkg::OP_QUERY, any_idx(), any_idx(),
					IW'($urandom_range(q_lim)));
			else if (r < 78)
				send_item(mscc_pkg::op_t'($urandom_range(1, 3)), any_idx(), any_idx(),
					any_idx());
		end
	endtask

	task automatic test_empty_table();
		send_item(mscc_pkg::OP_QUERY, '0, '0, '0);
		send_item(mscc_pkg::OP_QUERY, '1, '1, '1);
		send_item(mscc_pkg::OP_BACKWARD, '1, '1, '0);
		send_item(mscc_pkg::OP_BACKWARD, '0, '0, '1);
	endtask

	task automatic test_confirm_and_reuse();
		send_item(mscc_pkg::OP_FORWARD, '0, '1, '0);
		send_item(mscc_pkg::OP_FORWARD, '1, '0, '1);
		send_item(mscc_pkg::OP_BACKWARD, '0, '1, '0);
		send_item(mscc_pkg::OP_BACKWARD, '1, 10'd5, '0);
		send_item(mscc_pkg::OP_QUERY, '0, '0, 10'd0);
		send_item(mscc_pkg::OP_QUERY, '0, '0, 10'd1);
		send_item(mscc_pkg::OP_QUERY, '0, '0, 10'd2);
		// source 0 gets a new match; its old target no longer confirms
		send_item(mscc_pkg::OP_FORWARD, '0, 10'd7, '1);
		send_item(mscc_pkg::OP_BACKWARD, '0, '1, '0);
		send_item(mscc_pkg::OP_BACKWARD, '0, 10'd7, '0);
		send_item(mscc_pkg::OP_QUERY, '1, '1, 10'd0);
		send_item(mscc_pkg::OP_QUERY, '1, '1, 10'd2);
	endtask

	task automatic test_clear();
		send_item(mscc_pkg::OP_CLEAR, '1, '1, '1);
		send_item(mscc_pkg::OP_QUERY, '0, '0, 10'd0);
		send_item(mscc_pkg::OP_BACKWARD, '0, 10'd7, '0);
		send_item(mscc_pkg::OP_FORWARD, '1, '1, '0);
		send_item(mscc_pkg::OP_QUERY, '0, '0, 10'd0);
	endtask

	task automatic test_random_traffic();
		int burst;
		int first;
		burst = 0;
		first = n_sent;
		while (n_sent - first < RANDOM_ITEMS) begin
			gaps_on = (burst != 2);   // this burst runs back to back
			send_item(mscc_pkg::OP_CLEAR, any_idx(), any_idx(), any_idx());
			if (burst == 2) begin
				run_burst(150, 32);
			end else begin
				case ($urandom_range(2))
					0:       run_burst($urandom_range(8, 60), 4);
					1:       run_burst($urandom_range(8, 120), 32);
					default: run_burst($urandom_range(8, 120), N_SRC);
				endcase
			end
			burst++;
		end
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("result beat with nothing pending: status %0d index %0d confirmed %0d",
					status, match_index, confirmed);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				n_checked++;
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (match_index !== want.index) begin
					$error("match_index: expected %0d, got %0d", want.index, match_index);
					errors++;
				end
				if (confirmed !== want.confirmed) begin
					$error("confirmed: expected %0d, got %0d", want.confirmed, confirmed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still pending", cycles,
				verdict_q.size());
			$display("match_symmetry_cross_check regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = mscc_pkg::OP_CLEAR;
		source_feature = '0;
		target_feature = '0;
		match_number = '0;
		gaps_on = 1'b1;
		match_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_confirm_and_reuse();
		test_clear();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d items sent (%0d clears), %0d result beats checked, %0d confirming",
			n_sent, n_clears, n_checked, n_confirms);
		$display("covered empty lookups, source reuse, clears, idle gaps and a gapless burst");
		if (errors == 0)
			$display("match_symmetry_cross_check regression: pass");
		else
			$display("match_symmetry_cross_check regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
hdl/mscc_pkg.sv
hdl/mscc_ram.sv
hdl/match_symmetry_cross_check.sv
bench/tb_match_symmetry_cross_check.sv
